// ===== design/i2cra_pkg.sv =====
// i2cra_pkg: types and constants shared by the i2c register access unit
// no dependencies; used by every module of the block
package i2cra_pkg;

  // depth of the write byte buffer
  localparam int MaxBytes = 16;
  localparam int BufIdxW  = $clog2(MaxBytes);

  // acknowledge poll limit after reset
  localparam logic [15:0] AckPollReset = 16'd250;

  // tick within a bus slot on which the slot ends and sda is sampled
  localparam logic [1:0] TickLast = 2'd2;

  // command codes on the input stream
  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpPush  = 2'd1,
    OpStart = 2'd2,
    OpNone  = 2'd3
  } op_e;

  // status codes on the result stream
  typedef enum logic [1:0] {
    StRun      = 2'd0,
    StDone     = 2'd1,
    StAddrNack = 2'd2,
    StReject   = 2'd3
  } status_e;

  // bus sequencer phases
  typedef enum logic [4:0] {
    PhIdle    = 5'd0,
    PhStart   = 5'd1,
    PhTxDev   = 5'd2,
    PhAckDev  = 5'd3,
    PhTxReg   = 5'd4,
    PhAckReg  = 5'd5,
    PhTxData  = 5'd6,
    PhAckData = 5'd7,
    PhRstart  = 5'd8,
    PhTxRdev  = 5'd9,
    PhAckRdev = 5'd10,
    PhRx      = 5'd11,
    PhMack    = 5'd12,
    PhStopOk  = 5'd13,
    PhStopErr = 5'd14
  } phase_e;

  // one input item
  typedef struct packed {
    op_e        op;
    logic       sda_in;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic       is_read;
    logic [4:0] length;
    logic [7:0] write_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic       scl;
    logic       sda_level;
    logic       sda_is_input;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    status_e    status;
  } result_t;

endpackage

// ===== design/i2cra_in_reg.sv =====
// i2cra_in_reg: input register stage holding one accepted item
// depends on i2cra_pkg for the item type
module i2cra_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  i2cra_pkg::item_t item_i,
  output logic             valid_o,
  input  logic             take_i,
  output i2cra_pkg::item_t item_o
);

  logic             valid_q, valid_d;
  i2cra_pkg::item_t item_q;

  // free when empty or when the held item moves on this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/i2cra_out_reg.sv =====
// i2cra_out_reg: result register stage toward the output stream
// depends on i2cra_pkg for the result type
module i2cra_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  i2cra_pkg::result_t res_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               ready_i,
  output i2cra_pkg::result_t res_o
);

  logic               valid_q, valid_d;
  i2cra_pkg::result_t res_q;

  // can load when empty or when the held result is taken now
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== design/i2cra_seq.sv =====
// i2cra_seq: bus sequencer state, write buffer and poll limit register
// depends on i2cra_pkg; one item is processed in each cycle that fire_i is high
module i2cra_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               fire_i,
  input  i2cra_pkg::item_t   item_i,
  output i2cra_pkg::result_t res_o
);

  localparam int IdxW = i2cra_pkg::BufIdxW;

  i2cra_pkg::phase_e phase_q, phase_d;
  logic [1:0]  tick_q, tick_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [4:0]  byte_q, byte_d;
  logic [15:0] poll_q, poll_d;
  logic [4:0]  fill_q, fill_d;
  logic [7:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic        dir_q, dir_d;
  logic [4:0]  len_q, len_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        rel_q, rel_d;
  logic [15:0] limit_q;

  logic [7:0]  buf_q [i2cra_pkg::MaxBytes];
  logic        buf_we;

  logic [4:0]    byte_inc;
  logic [3:0]    bit_inc;
  logic [IdxW-1:0] rd_idx;
  logic [7:0]    rd_byte_q;
  logic          last;
  logic [7:0]    got_byte;
  logic          got_valid;
  logic          got_last;
  i2cra_pkg::status_e got_status;

  // acknowledge phase that follows each transmit phase
  function automatic i2cra_pkg::phase_e ack_of(input i2cra_pkg::phase_e ph);
    i2cra_pkg::phase_e r;
    unique case (ph)
      i2cra_pkg::PhTxDev:  r = i2cra_pkg::PhAckDev;
      i2cra_pkg::PhTxReg:  r = i2cra_pkg::PhAckReg;
      i2cra_pkg::PhTxData: r = i2cra_pkg::PhAckData;
      default:             r = i2cra_pkg::PhAckRdev;
    endcase
    return r;
  endfunction

  assign byte_inc = byte_q + 5'd1;
  assign bit_inc  = bit_q + 4'd1;
  assign last     = ({1'b0, byte_q} + 6'd1) >= {1'b0, len_q};

  // buffer read address: first byte after the register ack, else the next byte
  assign rd_idx  = (phase_q == i2cra_pkg::PhAckReg) ? '0 : byte_inc[IdxW-1:0];

  // next state and result for one item
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    byte_d  = byte_q;
    poll_d  = poll_q;
    fill_d  = fill_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    dir_d   = dir_q;
    len_d   = len_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rel_d   = rel_q;
    buf_we  = 1'b0;
    got_byte   = 8'd0;
    got_valid  = 1'b0;
    got_last   = 1'b0;
    got_status = i2cra_pkg::StRun;

    unique case (item_i.op)
      i2cra_pkg::OpTick: begin
        if (phase_q != i2cra_pkg::PhIdle) begin
          // line levels for this tick
          scl_d = (tick_q != 2'd0);
          unique case (phase_q)
            i2cra_pkg::PhStart, i2cra_pkg::PhRstart: begin
              rel_d = 1'b0;
              sda_d = (tick_q != i2cra_pkg::TickLast);
            end
            i2cra_pkg::PhTxDev, i2cra_pkg::PhTxReg,
            i2cra_pkg::PhTxData, i2cra_pkg::PhTxRdev: begin
              rel_d = 1'b0;
              sda_d = shift_q[7];
            end
            i2cra_pkg::PhMack: begin
              rel_d = 1'b0;
              sda_d = last;
            end
            i2cra_pkg::PhStopOk, i2cra_pkg::PhStopErr: begin
              rel_d = 1'b0;
              sda_d = (tick_q == i2cra_pkg::TickLast);
            end
            default: begin
              rel_d = 1'b1;
              sda_d = 1'b1;
            end
          endcase

          if (tick_q != i2cra_pkg::TickLast) begin
            tick_d = tick_q + 2'd1;
          end else begin
            // end of the slot
            tick_d = 2'd0;
            unique case (phase_q)
              i2cra_pkg::PhStart: begin
                phase_d = i2cra_pkg::PhTxDev;
                shift_d = dev_q;
                bit_d   = 4'd0;
              end
              i2cra_pkg::PhRstart: begin
                phase_d = i2cra_pkg::PhTxRdev;
                shift_d = dev_q + 8'd1;
                bit_d   = 4'd0;
              end
              i2cra_pkg::PhTxDev, i2cra_pkg::PhTxReg,
              i2cra_pkg::PhTxData, i2cra_pkg::PhTxRdev: begin
                shift_d = {shift_q[6:0], 1'b0};
                bit_d   = bit_inc;
                if (bit_inc >= 4'd8) begin
                  bit_d   = 4'd0;
                  poll_d  = 16'd0;
                  phase_d = ack_of(phase_q);
                end
              end
              i2cra_pkg::PhAckDev, i2cra_pkg::PhAckReg,
              i2cra_pkg::PhAckData, i2cra_pkg::PhAckRdev: begin
                poll_d = 16'd0;
                if (item_i.sda_in && (poll_q < limit_q)) begin
                  // keep polling at the sample tick
                  poll_d = poll_q + 16'd1;
                  tick_d = i2cra_pkg::TickLast;
                end else if (item_i.sda_in && (phase_q == i2cra_pkg::PhAckDev)) begin
                  phase_d = i2cra_pkg::PhStopErr;
                end else begin
                  // acknowledged, or a later timeout that is passed over
                  unique case (phase_q)
                    i2cra_pkg::PhAckDev: begin
                      phase_d = i2cra_pkg::PhTxReg;
                      shift_d = reg_q;
                      bit_d   = 4'd0;
                    end
                    i2cra_pkg::PhAckReg: begin
                      if (dir_q) begin
                        phase_d = i2cra_pkg::PhRstart;
                      end else if (len_q == 5'd0) begin
                        phase_d = i2cra_pkg::PhStopOk;
                      end else begin
                        phase_d = i2cra_pkg::PhTxData;
                        shift_d = rd_byte_q;
                        bit_d   = 4'd0;
                      end
                    end
                    i2cra_pkg::PhAckData: begin
                      byte_d = byte_inc;
                      if ((byte_inc < len_q) && (byte_inc < 5'(i2cra_pkg::MaxBytes))) begin
                        phase_d = i2cra_pkg::PhTxData;
                        shift_d = rd_byte_q;
                        bit_d   = 4'd0;
                      end else begin
                        phase_d = i2cra_pkg::PhStopOk;
                      end
                    end
                    default: begin
                      if (len_q == 5'd0) begin
                        phase_d = i2cra_pkg::PhStopOk;
                      end else begin
                        phase_d = i2cra_pkg::PhRx;
                        bit_d   = 4'd0;
                        shift_d = 8'd0;
                      end
                    end
                  endcase
                end
              end
              i2cra_pkg::PhRx: begin
                shift_d = {shift_q[6:0], item_i.sda_in};
                bit_d   = bit_inc;
                if (bit_inc >= 4'd8) begin
                  bit_d     = 4'd0;
                  got_byte  = {shift_q[6:0], item_i.sda_in};
                  got_valid = 1'b1;
                  got_last  = last;
                  phase_d   = i2cra_pkg::PhMack;
                end
              end
              i2cra_pkg::PhMack: begin
                byte_d = byte_inc;
                if (byte_inc < len_q) begin
                  phase_d = i2cra_pkg::PhRx;
                  shift_d = 8'd0;
                end else begin
                  phase_d = i2cra_pkg::PhStopOk;
                end
              end
              i2cra_pkg::PhStopOk, i2cra_pkg::PhStopErr: begin
                got_status = (phase_q == i2cra_pkg::PhStopOk) ?
                             i2cra_pkg::StDone : i2cra_pkg::StAddrNack;
                phase_d = i2cra_pkg::PhIdle;
                scl_d   = 1'b1;
                sda_d   = 1'b1;
                rel_d   = 1'b0;
              end
              default: begin
                phase_d = i2cra_pkg::PhIdle;
              end
            endcase
          end
        end
      end
      i2cra_pkg::OpPush: begin
        if ((phase_q == i2cra_pkg::PhIdle) && (fill_q < 5'(i2cra_pkg::MaxBytes))) begin
          buf_we = 1'b1;
          fill_d = fill_q + 5'd1;
        end else begin
          got_status = i2cra_pkg::StReject;
        end
      end
      i2cra_pkg::OpStart: begin
        if ((phase_q != i2cra_pkg::PhIdle) ||
            (item_i.length > 5'(i2cra_pkg::MaxBytes)) ||
            (!item_i.is_read && (item_i.length > fill_q))) begin
          got_status = i2cra_pkg::StReject;
        end else begin
          dev_d = item_i.dev_addr;
          reg_d = item_i.reg_addr;
          dir_d = item_i.is_read;
          len_d = item_i.length;
          if (!item_i.is_read) begin
            fill_d = 5'd0;
          end
          phase_d = i2cra_pkg::PhStart;
          tick_d  = 2'd0;
          bit_d   = 4'd0;
          byte_d  = 5'd0;
          poll_d  = 16'd0;
          shift_d = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // result of this item
  always_comb begin
    res_o.scl          = scl_d;
    res_o.sda_level    = sda_d;
    res_o.sda_is_input = rel_d;
    res_o.busy_res     = (phase_d != i2cra_pkg::PhIdle);
    res_o.read_byte    = got_byte;
    res_o.read_valid   = got_valid;
    res_o.read_last    = got_last;
    res_o.status       = got_status;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cra_pkg::PhIdle;
      tick_q  <= 2'd0;
      bit_q   <= 4'd0;
      shift_q <= 8'd0;
      byte_q  <= 5'd0;
      poll_q  <= 16'd0;
      fill_q  <= 5'd0;
      dev_q   <= 8'd0;
      reg_q   <= 8'd0;
      dir_q   <= 1'b0;
      len_q   <= 5'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      rel_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      byte_q  <= byte_d;
      poll_q  <= poll_d;
      fill_q  <= fill_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      dir_q   <= dir_d;
      len_q   <= len_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      rel_q   <= rel_d;
    end
  end

  // acknowledge poll limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= i2cra_pkg::AckPollReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // write byte buffer; registered read, the address holds through the whole ack slot
  always_ff @(posedge clk_i) begin
    if (fire_i && buf_we) begin
      buf_q[fill_q[IdxW-1:0]] <= item_i.write_byte;
    end
    rd_byte_q <= buf_q[rd_idx];
  end

endmodule

// ===== design/i2c_master_register_access_unit.sv =====
// i2c_master_register_access_unit: top level of the i2c register access master
// depends on i2cra_pkg, i2cra_in_reg, i2cra_seq and i2cra_out_reg
//
//   channel   direction  signals                         carries
//   s_axis    in         tvalid tready tdata tuser       commands, ticks, bytes
//   m_axis    out        tvalid tready tdata tlast       line levels and status
//   cfg       in         cfg_valid_i cfg_ready_o data    ack poll limit
//
// one item per cycle while the output is not stalled; each item passes an input
// register, the combinational sequencer logic and a result register, and its result
// is offered on m_axis from the result register.
// reset clears both stages and the sequencer; the poll limit returns to 250.
// a stall on m_axis holds the result register and backs up into s_axis.
// config is always accepted.
module i2c_master_register_access_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sda_in[0], dev_addr[8:1], reg_addr[16:9], is_read[17], length[22:18],
  // write_byte[30:23], zero[31]
  input  logic [31:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl[0], sda_level[1], sda_is_input[2], busy_res[3], read_byte[11:4],
  // read_valid[12], status[14:13], zero[15]
  output logic [15:0] m_axis_tdata,
  // read_last
  output logic        m_axis_tlast,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  i2cra_pkg::item_t   in_item;
  i2cra_pkg::item_t   held_item;
  i2cra_pkg::result_t seq_res;
  i2cra_pkg::result_t out_res;
  logic               held_valid;
  logic               out_free;
  logic               fire;

  // unpack the input transfer
  always_comb begin
    in_item.op         = i2cra_pkg::op_e'(s_axis_tuser);
    in_item.sda_in     = s_axis_tdata[0];
    in_item.dev_addr   = s_axis_tdata[8:1];
    in_item.reg_addr   = s_axis_tdata[16:9];
    in_item.is_read    = s_axis_tdata[17];
    in_item.length     = s_axis_tdata[22:18];
    in_item.write_byte = s_axis_tdata[30:23];
  end

  assign fire        = held_valid && out_free;
  assign cfg_ready_o = 1'b1;

  // input register
  i2cra_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (fire),
    .item_o  (held_item)
  );

  // sequencer
  i2cra_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (held_item),
    .res_o      (seq_res)
  );

  // result register
  i2cra_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .res_i   (seq_res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // pack the result transfer
  assign m_axis_tdata = {1'b0, out_res.status, out_res.read_valid, out_res.read_byte,
                         out_res.busy_res, out_res.sda_is_input, out_res.sda_level,
                         out_res.scl};
  assign m_axis_tlast = out_res.read_last;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// testbench for the i2c register access master: drives commands, ticks and limit writes,
// and checks every result against a built-in prediction of the bus sequencer
// depends on i2cra_pkg and i2c_master_register_access_unit
module testbench;
  import i2cra_pkg::*;

  localparam int CycleLimit = 300_000;

  // how the simulated device answers acknowledge slots
  typedef enum {AckAll, AckRandom, NackDev, NackLater} ack_plan_e;

  // prediction of the sequencer plus the queue of expected line levels
  class i2c_line_scoreboard;
    logic [15:0] limit;
    phase_e      ph;
    logic [1:0]  tick;
    logic [3:0]  bits;
    logic [7:0]  shreg;
    logic [4:0]  bytes;
    logic [15:0] polls;
    logic [7:0]  wbuf [MaxBytes];
    logic [4:0]  fill;
    logic [7:0]  dev;
    logic [7:0]  regad;
    logic        dir;
    logic [4:0]  len;
    logic        scl;
    logic        sda;
    logic        rel;
    result_t     expected_levels [$];
    int          failures;
    int          reported;
    int          results_seen;

    function new();
      limit = AckPollReset;
      ph = PhIdle;
      tick = '0;
      bits = '0;
      shreg = '0;
      bytes = '0;
      polls = '0;
      foreach (wbuf[i]) wbuf[i] = '0;
      fill = '0;
      dev = '0;
      regad = '0;
      dir = 1'b0;
      len = '0;
      scl = 1'b1;
      sda = 1'b1;
      rel = 1'b0;
      failures = 0;
      reported = 0;
      results_seen = 0;
    endfunction

    function void set_limit(logic [15:0] v);
      limit = v;
    endfunction

    function phase_e bus_phase();
      return ph;
    endfunction

    function bit is_busy();
      return ph != PhIdle;
    endfunction

    function int fill_level();
      return int'(fill);
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    function void load_byte(phase_e p, logic [7:0] v);
      ph = p;
      shreg = v;
      bits = '0;
    endfunction

    // next step once an acknowledge slot has ended
    function void acked();
      polls = '0;
      case (ph)
        PhAckDev: load_byte(PhTxReg, regad);
        PhAckReg: begin
          if (dir) ph = PhRstart;
          else if (len == 0) ph = PhStopOk;
          else load_byte(PhTxData, wbuf[0]);
        end
        PhAckData: begin
          bytes++;
          if (bytes < len && bytes < MaxBytes) load_byte(PhTxData, wbuf[bytes[3:0]]);
          else ph = PhStopOk;
        end
        default: begin
          if (len == 0) begin
            ph = PhStopOk;
          end else begin
            ph = PhRx;
            bits = '0;
            shreg = '0;
          end
        end
      endcase
    endfunction

    // one delay period of bus activity
    function void bus_tick(logic sda_in, inout result_t r);
      logic [1:0] t;
      logic       is_final;
      t = tick;
      is_final = (int'(bytes) + 1 >= int'(len));
      scl = (t == 2'd0) ? 1'b0 : 1'b1;
      case (ph)
        PhStart, PhRstart: begin
          rel = 1'b0;
          sda = (t != TickLast);
        end
        PhTxDev, PhTxReg, PhTxData, PhTxRdev: begin
          rel = 1'b0;
          sda = shreg[7];
        end
        PhMack: begin
          rel = 1'b0;
          sda = is_final;
        end
        PhStopOk, PhStopErr: begin
          rel = 1'b0;
          sda = (t == TickLast);
        end
        default: begin
          rel = 1'b1;
          sda = 1'b1;
        end
      endcase
      if (t != TickLast) begin
        tick = t + 2'd1;
        return;
      end
      case (ph)
        PhStart: begin
          tick = '0;
          load_byte(PhTxDev, dev);
        end
        PhRstart: begin
          tick = '0;
          load_byte(PhTxRdev, dev + 8'd1);
        end
        PhTxDev, PhTxReg, PhTxData, PhTxRdev: begin
          tick = '0;
          shreg = {shreg[6:0], 1'b0};
          bits++;
          if (bits >= 4'd8) begin
            bits = '0;
            polls = '0;
            ph = phase_e'(ph + 5'd1);
          end
        end
        PhAckDev, PhAckReg, PhAckData, PhAckRdev: begin
          // high sda holds the slot until the poll budget runs out
          if (sda_in && polls < limit) begin
            polls++;
          end else begin
            tick = '0;
            if (sda_in && ph == PhAckDev) begin
              polls = '0;
              ph = PhStopErr;
            end else begin
              acked();
            end
          end
        end
        PhRx: begin
          tick = '0;
          shreg = {shreg[6:0], sda_in};
          bits++;
          if (bits >= 4'd8) begin
            bits = '0;
            r.read_byte = shreg;
            r.read_valid = 1'b1;
            r.read_last = is_final;
            ph = PhMack;
          end
        end
        PhMack: begin
          tick = '0;
          bytes++;
          if (bytes < len) begin
            ph = PhRx;
            shreg = '0;
          end else begin
            ph = PhStopOk;
          end
        end
        PhStopOk, PhStopErr: begin
          r.status = (ph == PhStopOk) ? StDone : StAddrNack;
          tick = '0;
          ph = PhIdle;
          scl = 1'b1;
          sda = 1'b1;
          rel = 1'b0;
        end
        default: begin
          tick = '0;
          ph = PhIdle;
        end
      endcase
    endfunction

    function result_t predict_levels(item_t it);
      result_t r;
      r = '0;
      case (it.op)
        OpTick: if (ph != PhIdle) bus_tick(it.sda_in, r);
        OpPush: begin
          if (ph == PhIdle && fill < MaxBytes) begin
            wbuf[fill[3:0]] = it.write_byte;
            fill++;
          end else begin
            r.status = StReject;
          end
        end
        OpStart: begin
          if (ph != PhIdle || it.length > MaxBytes || (!it.is_read && it.length > fill)) begin
            r.status = StReject;
          end else begin
            dev = it.dev_addr;
            regad = it.reg_addr;
            dir = it.is_read;
            len = it.length;
            if (!it.is_read) fill = '0;
            ph = PhStart;
            tick = '0;
            bits = '0;
            bytes = '0;
            polls = '0;
            shreg = '0;
          end
        end
        default: ;
      endcase
      r.scl = scl;
      r.sda_level = sda;
      r.sda_is_input = rel;
      r.busy_res = (ph != PhIdle);
      return r;
    endfunction

    function void take_command(item_t it);
      expected_levels.push_back(predict_levels(it));
    endfunction

    function void check_levels(result_t got);
      result_t exp;
      bit      bad;
      results_seen++;
      if (expected_levels.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("result %0d arrived with nothing expected: %h", results_seen, got);
        end
        return;
      end
      exp = expected_levels.pop_front();
      bad = (got.scl !== exp.scl) || (got.sda_level !== exp.sda_level) ||
            (got.sda_is_input !== exp.sda_is_input) || (got.busy_res !== exp.busy_res) ||
            (got.read_byte !== exp.read_byte) || (got.read_valid !== exp.read_valid) ||
            (got.read_last !== exp.read_last) || (got.status !== exp.status);
      if (bad) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("result %0d mismatch: scl/sda/rel/busy expected %b%b%b%b got %b%b%b%b",
                   results_seen, exp.scl, exp.sda_level, exp.sda_is_input, exp.busy_res,
                   got.scl, got.sda_level, got.sda_is_input, got.busy_res);
          $display("  byte/valid/last/status expected %h %b %b %0d got %h %b %b %0d",
                   exp.read_byte, exp.read_valid, exp.read_last, exp.status,
                   got.read_byte, got.read_valid, got.read_last, got.status);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  i2c_line_scoreboard sb = new();
  int items_sent = 0;
  int send_rush = 0;
  int sink_rush = 0;
  int cycle_count = 0;
  bit hold_off = 1'b0;

  i2c_master_register_access_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL i2c_master_register_access_unit");
    $finish;
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    while (sb.results_seen < 500) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // result sink with random stalls
  initial begin : result_sink
    int      stall;
    result_t got;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (sink_rush > 0) begin
        stall = 0;
        sink_rush--;
      end else if ($urandom_range(0, 15) == 0) begin
        stall = 0;
        sink_rush = $urandom_range(20, 60);
      end else begin
        stall = $urandom_range(0, 5);
      end
      if (stall == 0 && hold_off) stall = 1;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (m_axis_tvalid !== 1'b1) @(posedge clk_i);
      got.scl = m_axis_tdata[0];
      got.sda_level = m_axis_tdata[1];
      got.sda_is_input = m_axis_tdata[2];
      got.busy_res = m_axis_tdata[3];
      got.read_byte = m_axis_tdata[11:4];
      got.read_valid = m_axis_tdata[12];
      got.status = status_e'(m_axis_tdata[14:13]);
      got.read_last = m_axis_tlast;
      sb.check_levels(got);
    end
  end

  function automatic item_t random_item(op_e op);
    item_t it;
    it.op = op;
    it.sda_in = 1'($urandom_range(0, 1));
    it.dev_addr = 8'($urandom_range(0, 255));
    it.reg_addr = 8'($urandom_range(0, 255));
    it.is_read = 1'($urandom_range(0, 1));
    it.length = 5'($urandom_range(0, 31));
    it.write_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // one transfer on the input stream after a random gap
  task automatic offer_item(input item_t it);
    int gap;
    if (send_rush > 0) begin
      gap = 0;
      send_rush--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      send_rush = $urandom_range(20, 60);
    end else begin
      gap = $urandom_range(0, 5);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, it.write_byte, it.length, it.is_read, it.reg_addr, it.dev_addr,
                     it.sda_in};
    s_axis_tuser <= it.op;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    if (it.op != OpNone && (it.op != OpTick || sb.is_busy())) items_sent++;
    sb.take_command(it);
  endtask

  task automatic push_byte(input logic [7:0] b);
    item_t it;
    it = random_item(OpPush);
    it.write_byte = b;
    offer_item(it);
  endtask

  task automatic start_cmd(input logic [7:0] dev, input logic [7:0] regad, input logic rd,
                           input logic [4:0] len);
    item_t it;
    it = random_item(OpStart);
    it.dev_addr = dev;
    it.reg_addr = regad;
    it.is_read = rd;
    it.length = len;
    offer_item(it);
  endtask

  task automatic tick_bus(input logic sda_in);
    item_t it;
    it = random_item(OpTick);
    it.sda_in = sda_in;
    offer_item(it);
  endtask

  // sda level the device shows on this tick
  function automatic logic pick_sda(ack_plan_e plan);
    logic coin;
    coin = ($urandom_range(0, 3) == 0);
    case (sb.bus_phase())
      PhAckDev: begin
        if (plan == NackDev) return 1'b1;
        if (plan == AckAll || plan == NackLater) return 1'b0;
        return coin;
      end
      PhAckReg, PhAckData, PhAckRdev: begin
        if (plan == NackLater) return 1'b1;
        if (plan == AckAll) return 1'b0;
        return coin;
      end
      default: return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // rejected or ignored traffic while the bus is running
  task automatic busy_noise();
    case ($urandom_range(0, 2))
      0: offer_item(random_item(OpPush));
      1: offer_item(random_item(OpStart));
      default: offer_item(random_item(OpNone));
    endcase
  endtask

  // ignored, refused or buffer-filling traffic while the bus is idle
  task automatic idle_noise();
    item_t it;
    case ($urandom_range(0, 4))
      0: it = random_item(OpNone);
      1: it = random_item(OpTick);
      2: begin
        it = random_item(OpStart);
        it.length = 5'($urandom_range(17, 31));
      end
      3: begin
        it = random_item(OpStart);
        it.is_read = 1'b0;
        if (sb.fill_level() < MaxBytes) begin
          it.length = 5'($urandom_range(sb.fill_level() + 1, MaxBytes));
        end else begin
          it.length = 5'($urandom_range(17, 31));
        end
      end
      default: it = random_item(OpPush);
    endcase
    offer_item(it);
  endtask

  // whole register transaction: fill the buffer for a write, start, tick until the bus is idle
  task automatic run_transfer(input logic rd, input logic [4:0] len, input logic [7:0] dev,
                              input logic [7:0] regad, input ack_plan_e plan, input bit poke,
                              input int noise_pct);
    while (!rd && sb.fill_level() < len) push_byte(8'($urandom_range(0, 255)));
    start_cmd(dev, regad, rd, len);
    if (poke) begin
      offer_item(random_item(OpStart));
      push_byte(8'($urandom_range(0, 255)));
    end
    while (sb.is_busy()) begin
      if ($urandom_range(0, 99) < noise_pct) busy_noise();
      else tick_bus(pick_sda(plan));
    end
  endtask

  // drain the pipeline before touching the limit register
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_limit(v);
    @(posedge clk_i);
  endtask

  task automatic random_round();
    ack_plan_e plan;
    logic [4:0] len;
    int pick;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 3)) idle_noise();
    end else begin
      plan = AckRandom;
      if (sb.limit <= 16'd20) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) plan = NackDev;
        else if (pick == 1) plan = NackLater;
        else if (pick == 2) plan = AckAll;
      end
      len = 5'($urandom_range(0, 3));
      run_transfer(1'($urandom_range(0, 1)), len, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), plan, ($urandom_range(0, 7) == 0), 3);
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    logic [15:0] limits [2];
    item_t       it;
    int          target;
    limits[0] = 16'hFFFF;
    limits[1] = 16'($urandom_range(2, 20));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // idle ticks and the unused code change nothing
    tick_bus(1'b0);
    tick_bus(1'b1);
    it = '1;
    offer_item(it);
    // starts refused on an empty buffer or an oversized length
    start_cmd(8'hA0, 8'h10, 1'b0, 5'd1);
    start_cmd(8'hA0, 8'h10, 1'b1, 5'd17);
    start_cmd(8'hFF, 8'hFF, 1'b1, 5'd31);
    // fill the buffer to the top, one more push is refused
    push_byte(8'h00);
    push_byte(8'hFF);
    repeat (MaxBytes - 2) push_byte(8'($urandom_range(0, 255)));
    push_byte(8'h5A);
    // longest write with polling, then a start and a push while busy
    run_transfer(1'b0, 5'd16, 8'h00, 8'hFF, AckRandom, 1'b1, 0);
    // single byte read, device byte wraps on the read address
    run_transfer(1'b1, 5'd1, 8'hFF, 8'h00, AckAll, 1'b0, 0);
    // zero length in both directions
    run_transfer(1'b0, 5'd0, 8'h3C, 8'hC3, AckAll, 1'b0, 0);
    run_transfer(1'b1, 5'd0, 8'hC3, 8'h3C, AckAll, 1'b0, 0);
    // timeouts with the smallest poll budget
    settle();
    write_limit(16'd1);
    run_transfer(1'b0, 5'd1, 8'h50, 8'h05, NackDev, 1'b0, 0);
    run_transfer(1'b1, 5'd1, 8'h51, 8'h06, NackLater, 1'b0, 0);

    // random rounds under two poll budgets
    foreach (limits[i]) begin
      settle();
      write_limit(limits[i]);
      target = items_sent + 60;
      while (items_sent < target) random_round();
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS i2c_master_register_access_unit");
    end else begin
      $display("FAIL i2c_master_register_access_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/i2cra_pkg.sv
design/i2cra_in_reg.sv
design/i2cra_out_reg.sv
design/i2cra_seq.sv
design/i2c_master_register_access_unit.sv
tb/sv/testbench.sv
